// File: rtl/counter_priority_task_scheduler_core_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CPTS_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define CPTS_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: rtl/cpts_pkg.sv
// Package for the counter priority task scheduler: widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpts_pkg;
    localparam int MaxTasks   = 64;
    localparam int IdxW       = 6;
    localparam int SliceW     = 9;
    localparam int PrioW      = 8;
    localparam int PreW       = 4;
    localparam int FuncW      = 3;

    localparam logic [FuncW-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FuncW-1:0] FUNC_YIELD = 3'd1;
    localparam logic [FuncW-1:0] FUNC_POFF  = 3'd2;
    localparam logic [FuncW-1:0] FUNC_PON   = 3'd3;
    localparam logic [FuncW-1:0] FUNC_WRITE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PICK, ST_CHARGE, ST_PICK2, ST_OUT
    } state_t;

    // Command broadcast to every cell in the same cycle
    typedef struct packed {
        logic              wr;       // load entry sel
        logic              tick;     // decrement entry sel
        logic              zero;     // clear counter of entry sel
        logic              pinc;
        logic              pdec;
        logic              charge;   // recharge all present entries
        logic              shift;    // rotate the ring one place
        logic [IdxW-1:0]   sel;
        logic              present;
        logic              running;
        logic [PrioW-1:0]  prio;
        logic [SliceW-1:0] slice;
    } cell_cmd_t;

    typedef struct packed {
        logic              present;
        logic              running;
        logic [SliceW-1:0] slice;
        logic [PreW-1:0]   preempt;
        logic [PrioW-1:0]  prio;
    } entry_t;
endpackage
`default_nettype wire

// File: rtl/cpts_cell.sv
// One task-table cell of the scheduler ring; on shift it takes the entry of the cell one index above.
// Depends on cpts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpts_cell (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        is_zero,
    input  wire  [cpts_pkg::IdxW-1:0]  my_slot,
    input  wire  [cpts_pkg::IdxW-1:0]  rot,
    input  wire  cpts_pkg::cell_cmd_t  cmd,
    input  wire  cpts_pkg::entry_t     prev_entry,
    output cpts_pkg::entry_t           entry
);
    import cpts_pkg::*;

    entry_t entry_reg, entry_next;
    logic   hit;
    logic [SliceW:0] rc;

    // slot held here is (my_slot + rot) mod MaxTasks
    assign hit = (IdxW'(my_slot + rot) == cmd.sel);
    assign rc  = {1'b0, 1'b0, entry_reg.slice[SliceW-1:1]} + (SliceW+1)'(entry_reg.prio);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.shift) begin
            entry_next = prev_entry;
        end else if (cmd.charge) begin
            if (entry_reg.present)
                entry_next.slice = rc[SliceW] ? '1 : rc[SliceW-1:0];
        end else if (hit) begin
            if (cmd.wr) begin
                entry_next.present = cmd.present;
                entry_next.running = cmd.running;
                entry_next.prio    = cmd.prio;
                entry_next.slice   = cmd.slice;
                entry_next.preempt = '0;
            end
            if (cmd.tick && entry_reg.slice != '0)
                entry_next.slice = entry_reg.slice - SliceW'(1);
            if (cmd.zero)
                entry_next.slice = '0;
            if (cmd.pinc && entry_reg.preempt != '1)
                entry_next.preempt = entry_reg.preempt + PreW'(1);
            if (cmd.pdec && entry_reg.preempt != '0)
                entry_next.preempt = entry_reg.preempt - PreW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.present <= is_zero;
            entry_reg.running <= is_zero;
            entry_reg.slice   <= '0;
            entry_reg.preempt <= '0;
            entry_reg.prio    <= PrioW'(1);
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
endmodule
`default_nettype wire

// File: rtl/counter_priority_task_scheduler_core.sv
// Counter priority task scheduler top level: control sequencer over a ring of cells.
// Depends on cpts_pkg, cpts_cell and the macros header.
//
// Usage:
//  s_axis carries one operation per item; tdata packs func, task_index,
//  task_present, task_is_running, task_prio, task_slice from bit 0 up.
//  m_axis returns exactly one result per item: current_task, switched,
//  current_slice from bit 0 up.
//  Preempt, task write and ticks that do not reschedule answer from the
//  output state. A reschedule rotates the 64-cell ring once to pick;
//  when all runnable counters are zero it recharges and rotates again.
//  One item is processed at a time; the next is taken once the result
//  register is free or being emptied.
//  Reset (aresetn low, synchronous) loads task 0 present and running,
//  all counters zero, priorities one, current task 0.
//  A stalled receiver holds m_axis_tdata stable; no input is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "counter_priority_task_scheduler_core_macros.svh"
module counter_priority_task_scheduler_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], task_index[8:3], task_present[9], task_is_running[10],
    // task_prio[18:11], task_slice[27:19], zero fill [31:28]
    input  wire  [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // current_task[5:0], switched[6], current_slice[15:7]
    output logic [15:0] m_axis_tdata
);
    import cpts_pkg::*;

    localparam int CntW = IdxW + 1;

    state_t state_reg, state_next;
    logic [IdxW-1:0]   cur_reg, cur_next, before_reg, before_next;
    logic [IdxW-1:0]   rot_reg, rot_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic [SliceW-1:0] best_reg, best_next;
    logic [IdxW-1:0]   who_reg, who_next;
    logic              ov_reg, ov_next;
    logic [15:0]       od_reg, od_next;
    logic [31:0]       in_reg, in_next;
    cell_cmd_t         cmd;
    entry_t            ent [MaxTasks];
    entry_t            head;
    logic              take, pick_done, head_run;
    logic [SliceW-1:0] cur_slice;
    logic [FuncW-1:0]  f;

    genvar g;
    generate
        for (g = 0; g < MaxTasks; g++) begin : g_cell
            cpts_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .is_zero   (g == 0),
                .my_slot   (IdxW'(g)),
                .rot       (rot_reg),
                .cmd       (cmd),
                .prev_entry(ent[(g + 1) % MaxTasks]),
                .entry     (ent[g])
            );
        end
    endgenerate

    // cell 0 holds slot rot_reg; current slot is reached via cell (cur - rot)
    assign head      = ent[0];
    assign head_run  = head.present && head.running;
    assign cur_slice = ent[IdxW'(cur_reg - rot_reg)].slice;
    assign f         = in_reg[2:0];
    assign take      = s_axis_tvalid && s_axis_tready;
    assign pick_done = (cnt_reg == CntW'(MaxTasks - 1));

    assign s_axis_tready = (state_reg == ST_IDLE) && (!ov_reg || m_axis_tready);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (take) state_next = ST_OUT;
            ST_OUT: begin
                if ((f == FUNC_YIELD) ||
                    (f == FUNC_TICK && cur_slice == '0 &&
                     ent[IdxW'(cur_reg - rot_reg)].preempt == '0))
                    state_next = ST_PICK;
                else
                    state_next = ST_IDLE;
            end
            ST_PICK: if (pick_done) state_next = ST_CHARGE;
            ST_CHARGE: begin
                if (found_reg && best_reg == '0)
                    state_next = ST_PICK2;
                else
                    state_next = ST_IDLE;
            end
            ST_PICK2: if (pick_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.sel     = cur_reg;
        cur_next    = cur_reg;
        before_next = before_reg;
        rot_next    = rot_reg;
        cnt_next    = cnt_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        who_next    = who_reg;
        ov_next     = ov_reg && !m_axis_tready;
        od_next     = od_reg;
        in_next     = in_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    in_next     = s_axis_tdata;
                    before_next = cur_reg;
                    cmd.sel     = s_axis_tdata[8:3];
                    case (s_axis_tdata[2:0])
                        FUNC_TICK:  cmd.tick = 1'b1;
                        FUNC_YIELD: cmd.zero = 1'b1;
                        FUNC_POFF:  cmd.pinc = 1'b1;
                        FUNC_PON:   cmd.pdec = 1'b1;
                        FUNC_WRITE: cmd.wr   = 1'b1;
                        default:    cmd.wr   = 1'b0;
                    endcase
                    if (s_axis_tdata[2:0] != FUNC_WRITE) cmd.sel = cur_reg;
                    cmd.present = s_axis_tdata[9];
                    cmd.running = s_axis_tdata[10];
                    cmd.prio    = s_axis_tdata[18:11];
                    cmd.slice   = s_axis_tdata[27:19];
                end
            end
            ST_OUT: begin
                cnt_next   = '0;
                found_next = 1'b0;
                best_next  = '0;
                who_next   = '0;
                if (state_next == ST_IDLE) begin
                    ov_next = 1'b1;
                    od_next = {cur_slice, 1'b0, cur_reg};
                end
            end
            ST_PICK, ST_PICK2: begin
                if (head_run && (!found_reg || head.slice > best_reg)) begin
                    found_next = 1'b1;
                    best_next  = head.slice;
                    who_next   = rot_reg;
                end
                cmd.shift = 1'b1;
                rot_next  = rot_reg + IdxW'(1);
                cnt_next  = cnt_reg + CntW'(1);
                if (state_reg == ST_PICK2 && pick_done) begin
                    cur_next = found_next ? who_next : cur_reg;
                    ov_next  = 1'b1;
                    od_next  = {ent[IdxW'((found_next ? who_next : cur_reg) - rot_reg)].slice,
                                (found_next ? who_next : cur_reg) != before_reg,
                                found_next ? who_next : cur_reg};
                end
            end
            ST_CHARGE: begin
                // ring is back at rot 0 here
                if (found_reg && best_reg == '0) begin
                    cmd.charge = 1'b1;
                    cnt_next   = '0;
                    best_next  = '0;
                    found_next = 1'b1;
                    who_next   = '0;
                end else begin
                    cur_next = found_reg ? who_reg : cur_reg;
                    ov_next  = 1'b1;
                    od_next  = {ent[IdxW'((found_reg ? who_reg : cur_reg) - rot_reg)].slice,
                                (found_reg ? who_reg : cur_reg) != before_reg,
                                found_reg ? who_reg : cur_reg};
                end
                if (found_reg && best_reg == '0) found_next = 1'b0;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            rot_reg   <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            rot_reg   <= rot_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            ov_reg    <= ov_next;
        end
        before_reg <= before_next;
        best_reg   <= best_next;
        who_reg    <= who_next;
        od_reg     <= od_next;
        in_reg     <= in_next;
    end

    `CPTS_ASSERT_IMP(a_idle_rot, aclk, aresetn, state_reg == ST_IDLE, rot_reg == '0)
    `CPTS_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `CPTS_ASSERT_IMP(a_no_take_busy, aclk, aresetn, state_reg != ST_IDLE, !s_axis_tready)
endmodule
`default_nettype wire

// File: bench/counter_priority_task_scheduler_core_tb.sv
// Testbench for counter_priority_task_scheduler_core: drives operation items,
// predicts each result with a local task-table model and checks every result item.
// Depends on cpts_pkg and the scheduler RTL.
`timescale 1ns / 1ps
`default_nettype none

class sched_scoreboard;
    bit                    present[cpts_pkg::MaxTasks];
    bit                    running[cpts_pkg::MaxTasks];
    bit [cpts_pkg::SliceW-1:0] slice[cpts_pkg::MaxTasks];
    bit [cpts_pkg::PrioW-1:0]  prio[cpts_pkg::MaxTasks];
    bit [cpts_pkg::PreW-1:0]   preempt[cpts_pkg::MaxTasks];
    bit [cpts_pkg::IdxW-1:0]   cur;
    bit [15:0] expected_results[$];
    int mismatches;

    function new();
        for (int i = 0; i < cpts_pkg::MaxTasks; i++) begin
            present[i] = (i == 0);
            running[i] = (i == 0);
            slice[i] = '0;
            prio[i] = 8'd1;
            preempt[i] = '0;
        end
        cur = '0;
        mismatches = 0;
    endfunction

    function bit find_best(output bit [5:0] who, output bit [8:0] best);
        bit found;
        found = 1'b0;
        who = '0;
        best = '0;
        for (int i = 0; i < cpts_pkg::MaxTasks; i++) begin
            if (present[i] && running[i] && (!found || slice[i] > best)) begin
                found = 1'b1;
                best = slice[i];
                who = 6'(i);
            end
        end
        return found;
    endfunction

    function void pick_next();
        bit [5:0] who;
        bit [8:0] best;
        bit [9:0] v;
        if (!find_best(who, best)) return;
        if (best == 9'd0) begin
            for (int i = 0; i < cpts_pkg::MaxTasks; i++) begin
                if (present[i]) begin
                    v = 10'(slice[i] >> 1) + 10'(prio[i]);
                    slice[i] = (v > 10'd511) ? 9'h1FF : v[8:0];
                end
            end
            void'(find_best(who, best));
        end
        cur = who;
    endfunction

    function void note_item(bit [31:0] d);
        bit [2:0] op;
        bit [5:0] idx;
        bit [5:0] prev;
        op = d[2:0];
        idx = d[8:3];
        prev = cur;
        case (op)
            cpts_pkg::FUNC_TICK: begin
                if (slice[cur] > 0) slice[cur]--;
                if (slice[cur] == 0 && preempt[cur] == 0) pick_next();
            end
            cpts_pkg::FUNC_YIELD: begin
                slice[cur] = '0;
                pick_next();
            end
            cpts_pkg::FUNC_POFF: if (preempt[cur] < 15) preempt[cur]++;
            cpts_pkg::FUNC_PON:  if (preempt[cur] > 0) preempt[cur]--;
            cpts_pkg::FUNC_WRITE: begin
                present[idx] = d[9];
                running[idx] = d[10];
                prio[idx] = d[18:11];
                slice[idx] = d[27:19];
                preempt[idx] = '0;
            end
            default: ;
        endcase
        expected_results.push_back({slice[cur], (cur != prev), cur});
    endfunction

    function void check_result(bit [15:0] got);
        bit [15:0] exp;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", got);
            return;
        end
        exp = expected_results.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: task %0d/%0d switched %0d/%0d slice %0d/%0d (exp/got)",
                         exp[5:0], got[5:0], exp[6], got[6], exp[15:7], got[15:7]);
        end
    endfunction
endclass

module counter_priority_task_scheduler_core_tb;
    import cpts_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // func[2:0], task_index[8:3], task_present[9], task_is_running[10],
    // task_prio[18:11], task_slice[27:19], zero fill [31:28]
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // current_task[5:0], switched[6], current_slice[15:7]
    logic [15:0] m_axis_tdata;

    sched_scoreboard sb;
    bit    calm;
    int    cycles = 0;
    int    stall_left = 0;

    counter_priority_task_scheduler_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit [31:0] make_item(bit [2:0] op, bit [5:0] idx, bit pr, bit rn,
                                            bit [7:0] pri, bit [8:0] sl);
        return {4'b0, sl, pri, rn, pr, idx, op};
    endfunction

    // drop valid only for an idle burst; otherwise the next item follows directly
    task automatic send_item(bit [31:0] d);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(d);
    endtask

    task automatic send_random();
        int r;
        bit [2:0] op;
        bit [5:0] idx;
        bit       pr;
        bit       rn;
        bit [7:0] pri;
        bit [8:0] sl;
        r = $urandom_range(0, 99);
        if (r < 35)      op = FUNC_TICK;
        else if (r < 50) op = FUNC_YIELD;
        else if (r < 58) op = FUNC_POFF;
        else if (r < 68) op = FUNC_PON;
        else if (r < 97) op = FUNC_WRITE;
        else             op = 3'($urandom_range(5, 7));
        idx = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 7));
        pr  = ($urandom_range(0, 4) != 0);
        rn  = ($urandom_range(0, 2) != 0);
        pri = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        sl  = ($urandom_range(0, 2) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(0, 6));
        send_item(make_item(op, idx, pr, rn, pri, sl));
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
        if (cycles > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        sb = new();
        calm = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: reset state, extremes, every operation
        send_item(make_item(FUNC_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_YIELD, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_WRITE, 6'd63, 1'b1, 1'b1, 8'd255, 9'd511));
        send_item(make_item(FUNC_WRITE, 6'd5, 1'b1, 1'b1, 8'd1, 9'd511));
        send_item(make_item(FUNC_TICK, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_YIELD, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        for (int i = 0; i < 17; i++)
            send_item(make_item(FUNC_POFF, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_YIELD, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_PON, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_WRITE, 6'd63, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_WRITE, 6'd5, 1'b0, 1'b1, 8'd0, 9'd0));
        send_item(make_item(FUNC_WRITE, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_YIELD, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(FUNC_WRITE, 6'd2, 1'b1, 1'b1, 8'd0, 9'd0));
        send_item(make_item(FUNC_WRITE, 6'd3, 1'b1, 1'b1, 8'd0, 9'd0));
        send_item(make_item(FUNC_YIELD, 6'd0, 1'b0, 1'b0, 8'd0, 9'd0));
        send_item(make_item(3'd7, 6'h3F, 1'b1, 1'b1, 8'hFF, 9'h1FF));
        for (int i = 0; i < 1700; i++) begin
            if (i == 1500) calm = 1'b1;
            send_random();
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b1;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
